// ===== src/header_length_sum_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the header/length/sum frame parser
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_SUM_FRAME_PARSER_CORE_ASSERT_SVH
`define HEADER_LENGTH_SUM_FRAME_PARSER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hfp assertion failed");
`define HFP_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("hfp forbidden condition seen");
`else
`define HFP_ASSERT(lbl, clk, rstn, prop)
`define HFP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== src/hfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hfp_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hfp_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
  localparam logic [7:0] MAX_LEN_RST   = 8'd103;

  localparam logic [7:0] POS_HDR0 = 8'd0;
  localparam logic [7:0] POS_HDR1 = 8'd1;
  localparam logic [7:0] POS_LEN  = 8'd2;
  localparam logic [7:0] POS_INST = 8'd3;

  typedef enum logic [2:0] {
    ST_DISCARD = 3'd0,
    ST_HEADER  = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_BODY    = 3'd3,
    ST_OK      = 3'd4,
    ST_BADSUM  = 3'd5,
    ST_BADLEN  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] position;
    status_e    status;
    logic [7:0] instruction;
    logic [7:0] frame_len;
  } result_t;

endpackage

`default_nettype wire

// ===== src/hfp_deframer.sv =====
// ----------------------------------------------------------------------------
// hfp_deframer
// Frame state and per-byte step: header hunt, length check, running sum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_length_sum_frame_parser_core_assert.svh"

module hfp_deframer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [7:0]      max_frame_len_i,
  output hfp_pkg::result_t     res_o
);
  import hfp_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] inst_q, inst_d;
  logic [8:0] pos_inc;
  logic       last_byte;

  assign pos_inc   = {1'b0, pos_q} + 9'd1;
  assign last_byte = pos_inc >= {1'b0, len_q};

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    sum_d  = sum_q;
    inst_d = inst_q;
    res_o.data_byte   = rx_byte_i;
    res_o.position    = pos_q;
    res_o.status      = ST_DISCARD;
    res_o.instruction = 8'd0;
    res_o.frame_len   = 8'd0;
    if (pos_q == POS_HDR0) begin
      if (rx_byte_i == HDR_BYTE) begin
        res_o.status = ST_HEADER;
        pos_d        = POS_HDR1;
      end
    end else if (pos_q == POS_HDR1) begin
      if (rx_byte_i == HDR_BYTE) begin
        res_o.status = ST_HEADER;
        pos_d        = POS_LEN;
      end else begin
        pos_d = POS_HDR0;
      end
    end else if (pos_q == POS_LEN) begin
      res_o.frame_len = rx_byte_i;
      if (rx_byte_i < MIN_FRAME_LEN || rx_byte_i > max_frame_len_i) begin
        res_o.status = ST_BADLEN;
        pos_d        = POS_HDR0;
      end else begin
        res_o.status = ST_LENGTH;
        len_d        = rx_byte_i;
        sum_d        = rx_byte_i;
        pos_d        = POS_INST;
      end
    end else begin
      res_o.frame_len = len_q;
      if (last_byte) begin
        if (rx_byte_i == sum_q) begin
          res_o.status      = ST_OK;
          res_o.instruction = inst_q;
        end else begin
          res_o.status = ST_BADSUM;
        end
        pos_d  = POS_HDR0;
        len_d  = 8'd0;
        sum_d  = 8'd0;
        inst_d = 8'd0;
      end else begin
        res_o.status = ST_BODY;
        if (pos_q == POS_INST) begin
          inst_d = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      len_q  <= 8'd0;
      sum_q  <= 8'd0;
      inst_q <= 8'd0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
      inst_q <= inst_d;
    end
  end

  `HFP_ASSERT(a_hunt_clear, clk_i, rst_ni, (pos_q < POS_INST) |-> (len_q == 8'd0 && sum_q == 8'd0))
  `HFP_ASSERT(a_body_in_frame, clk_i, rst_ni, (pos_q >= POS_INST) |-> (len_q >= MIN_FRAME_LEN && pos_inc <= {1'b0, len_q}))
  `HFP_ASSERT(a_end_hunts, clk_i, rst_ni, (step_i && (res_o.status == ST_OK || res_o.status == ST_BADSUM || res_o.status == ST_BADLEN)) |=> (pos_q == POS_HDR0))
  `HFP_ASSERT_NEVER(a_len_bound, clk_i, rst_ni, step_i && res_o.status == ST_LENGTH && rx_byte_i > max_frame_len_i)

endmodule

`default_nettype wire

// ===== src/header_length_sum_frame_parser_core.sv =====
// A byte passes from the accepting edge through the input and result registers to out_valid_o.
// Throughput: one byte per cycle while out_stall_i is low; the step is byte compares and 8-bit adds.
// Stall from the output propagates to in_stall_o only when both registers are full.
// Reset clears the frame state to header hunt and max_frame_len to 103.
// ----------------------------------------------------------------------------
// header_length_sum_frame_parser_core
// FF FF / length / checksum deframer with cut-through per-byte results.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_sum_frame_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_max_frame_len_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      position_o,
  output logic [2:0]      status_o,
  output logic [7:0]      instruction_o,
  output logic [7:0]      frame_len_o
);
  import hfp_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_q;
  result_t    res;
  logic [7:0] max_len_q;
  logic       in_take;
  logic       step;

  assign cfg_ready_o = 1'b1;

  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      max_len_q <= MAX_LEN_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_frame_len_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  hfp_deframer u_deframer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .rx_byte_i       (in_byte_q),
    .max_frame_len_i (max_len_q),
    .res_o           (res)
  );

  assign out_valid_o   = out_vld_q;
  assign data_byte_o   = out_q.data_byte;
  assign position_o    = out_q.position;
  assign status_o      = out_q.status;
  assign instruction_o = out_q.instruction;
  assign frame_len_o   = out_q.frame_len;

endmodule

`default_nettype wire

// ===== dv/header_length_sum_frame_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// header_length_sum_frame_parser_core_test
// Drives received bytes through the deframer under random idling on both
// sides. A byte-level predictor tracks the header hunt, the length check and
// the running checksum, and every result is checked field by field. Runs
// several max_frame_len settings, including 0, 4, 5 and 255.
// ----------------------------------------------------------------------------
module header_length_sum_frame_parser_core_test;
  import hfp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 300;
  localparam int SETTLE_TICKS = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic       out_stall = 1'b0;

  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic [7:0] position_o;
  logic [2:0] status_o;
  logic [7:0] instruction_o;
  logic [7:0] frame_len_o;

  header_length_sum_frame_parser_core u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_max_frame_len_i(cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .data_byte_o        (data_byte_o),
    .position_o         (position_o),
    .status_o           (status_o),
    .instruction_o      (instruction_o),
    .frame_len_o        (frame_len_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [7:0] hunt_pos    = POS_HDR0;
  logic [7:0] frame_length = 8'd0;
  logic [7:0] sum_acc     = 8'd0;
  logic [7:0] inst_held   = 8'd0;
  logic [7:0] max_len_cfg = MAX_LEN_RST;

  logic [7:0] pending_bytes_q[$];
  result_t    expected_results_q[$];
  result_t    want;

  int  bytes_queued   = 0;
  int  bytes_accepted = 0;
  int  cfg_writes     = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  seen_status[8];
  bit  in_taken       = 1'b0;
  bit  send_burst     = 1'b0;
  bit  recv_burst     = 1'b0;
  int  send_gap       = 0;
  int  recv_wait      = 0;
  logic [7:0] plan[6];

  function automatic void restart_hunt();
    hunt_pos     = POS_HDR0;
    frame_length = 8'd0;
    sum_acc      = 8'd0;
    inst_held    = 8'd0;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r.data_byte   = b;
    r.position    = hunt_pos;
    r.instruction = 8'd0;
    r.frame_len   = 8'd0;
    r.status      = ST_DISCARD;
    if (hunt_pos == POS_HDR0) begin
      if (b == HDR_BYTE) begin
        r.status = ST_HEADER;
        hunt_pos = POS_HDR1;
      end
    end else if (hunt_pos == POS_HDR1) begin
      if (b == HDR_BYTE) begin
        r.status = ST_HEADER;
        hunt_pos = POS_LEN;
      end else begin
        restart_hunt();
      end
    end else if (hunt_pos == POS_LEN) begin
      r.frame_len = b;
      if (b < MIN_FRAME_LEN || b > max_len_cfg) begin
        r.status = ST_BADLEN;
        restart_hunt();
      end else begin
        r.status     = ST_LENGTH;
        frame_length = b;
        sum_acc      = b;
        hunt_pos     = POS_INST;
      end
    end else begin
      r.frame_len = frame_length;
      if ({1'b0, hunt_pos} + 9'd1 >= {1'b0, frame_length}) begin
        if (b == sum_acc) begin
          r.status      = ST_OK;
          r.instruction = inst_held;
        end else begin
          r.status = ST_BADSUM;
        end
        restart_hunt();
      end else begin
        r.status = ST_BODY;
        if (hunt_pos == POS_INST) inst_held = b;
        sum_acc  = sum_acc + b;
        hunt_pos = hunt_pos + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // stalled, hold the item
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes_q.size() != 0) begin
        rx_byte  <= pending_bytes_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_wait != 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_results_q.size());
      $display("FAIL header_length_sum_frame_parser_core");
      $finish;
    end else if (rst_n) begin
      in_taken = in_valid && !in_stall_o;
      if (in_taken) begin
        expected_results_q.push_back(deframe_byte(rx_byte));
        bytes_accepted++;
      end
      if (cfg_valid && cfg_ready_o) begin
        max_len_cfg = cfg_data;
        cfg_writes++;
      end
      if (out_valid_o && !out_stall) begin
        seen_status[status_o]++;
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %0h status %0d",
                   $time, data_byte_o, status_o);
          mismatches++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("position", want.position, position_o);
          check_field("status", {5'd0, want.status}, {5'd0, status_o});
          check_field("instruction", want.instruction, instruction_o);
          check_field("frame_len", want.frame_len, frame_len_o);
        end
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] len, input logic [7:0] inst, input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] ck;
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(len);
    push_byte(inst);
    sum = len + inst;
    for (int i = 0; i < int'(len) - 5; i++) begin
      b = ($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
      push_byte(b);
      sum = sum + b;
    end
    ck = good ? sum : sum + 8'($urandom_range(1, 255));
    push_byte(ck);
  endtask

  function automatic logic [7:0] pick_len(input logic [7:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (m < MIN_FRAME_LEN) return 8'($urandom_range(5, 20));
    if (r < 85) return 8'($urandom_range(5, (m < 16) ? int'(m) : 16));
    if (r < 95) return 8'($urandom_range(5, int'(m)));
    return m;
  endfunction

  task automatic random_item();
    int pick;
    logic [7:0] m;
    m = max_len_cfg;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      push_frame(pick_len(m), 8'($urandom_range(0, 255)), $urandom_range(0, 6) != 0);
    end else if (pick < 80) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      push_byte(HDR_BYTE);
      push_byte(8'($urandom_range(0, 254)));
    end else if (pick < 93) begin
      push_byte(HDR_BYTE);
      push_byte(HDR_BYTE);
      if (m == 8'd255 || $urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 4)));
      else push_byte(8'($urandom_range(int'(m) + 1, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) push_byte(HDR_BYTE);
    end
  endtask

  task automatic drain();
    while (bytes_accepted != bytes_queued || expected_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [7:0] v);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // half the bytes, full pause until all results are back, then the rest
  task automatic run_phase();
    int stop;
    for (int half = 0; half < 2; half++) begin
      stop = bytes_queued + PHASE_BYTES / 2;
      if (half == 0 && max_len_cfg >= MIN_FRAME_LEN) push_frame(max_len_cfg, 8'hFF, 1'b1);
      while (bytes_queued < stop) random_item();
      drain();
    end
  endtask

  initial begin
    plan[0] = 8'd255;
    plan[1] = MIN_FRAME_LEN;
    plan[2] = 8'd0;
    plan[3] = 8'd4;
    plan[4] = 8'($urandom_range(6, 254));
    plan[5] = MAX_LEN_RST;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: hunt noise, broken header, short and long lengths,
    // minimal good frame, FF FF inside a body, bad checksum
    push_byte(8'h00);
    push_byte(HDR_BYTE);
    push_byte(8'h12);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(8'd4);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(MAX_LEN_RST + 8'd1);
    push_frame(MIN_FRAME_LEN, 8'hA5, 1'b1);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(8'd7);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(HDR_BYTE);
    push_byte(8'h04);
    push_frame(MIN_FRAME_LEN, 8'h00, 1'b0);

    run_phase();
    foreach (plan[i]) begin
      write_max_len(plan[i]);
      run_phase();
    end
    drain();
    repeat (20) @(negedge clk);

    $display("Run covered %0d bytes over %0d max_frame_len settings (0, 4, 5, 255 included)",
             bytes_accepted, 7);
    $display("Results: %0d good frames, %0d bad checksums, %0d bad lengths, %0d discards",
             seen_status[ST_OK], seen_status[ST_BADSUM], seen_status[ST_BADLEN],
             seen_status[ST_DISCARD]);
    if (mismatches == 0) begin
      $display("PASS header_length_sum_frame_parser_core");
    end else begin
      $display("FAIL header_length_sum_frame_parser_core");
    end
    $finish;
  end

endmodule
